>>> rtl/core/ftgm_pkg.sv
// Shared types, constants and codes of the frame timestamp gap monitor.
package ftgm_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int DIV_STEPS          = 64;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 32;
    localparam int BYTE_W             = 48;

    localparam logic [31:0] TICKS_PER_SECOND  = 32'd10_000_000;
    localparam logic [63:0] SIGN64            = 64'h8000_0000_0000_0000;
    localparam logic [31:0] INTERVAL_RESET    = 32'd333_333;
    localparam logic [15:0] DURATION_RESET    = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINALIZE       = 2'd2;

    typedef enum logic [1:0] {
        DISC_NONE       = 2'd0,
        DISC_REGRESSION = 2'd1,
        DISC_GAP        = 2'd2
    } disc_t;

    typedef enum logic [2:0] {
        STOP_RUNNING    = 3'd0,
        STOP_DURATION   = 3'd1,
        STOP_END        = 3'd2,
        STOP_READ_ERROR = 3'd3,
        STOP_ERROR_FLAG = 3'd4,
        STOP_ABORTED    = 3'd5
    } stop_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_REG,
        S_STEP,
        S_GAP,
        S_DIV,
        S_DROP,
        S_NORM,
        S_LIMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic signed [63:0] event_time;
        logic               sample_present;
        logic [31:0]        sample_bytes;
        logic               read_failed;
        logic               error_flag;
        logic               tick_flag;
        logic               type_changed;
        logic               stream_end;
    } event_word_t;

    typedef struct packed {
        logic [31:0]        frame_sequence;
        logic [1:0]         discontinuity;
        logic [31:0]        frames_missed;
        logic signed [63:0] normalized_time;
        logic [2:0]         stop_reason;
        logic [47:0]        byte_total;
        logic [31:0]        tick_total;
        logic [31:0]        regression_total;
    } result_word_t;

endpackage

>>> rtl/core/ftgm_chan_if.sv
// Valid/ready channel interface carrying one word of a given type.
interface ftgm_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/frame_timestamp_gap_monitor.sv
// Frame timestamp gap monitor: sequencer around one shared 64-bit subtractor.
//
//  channel    | direction | word          | handshake
//  -----------+-----------+---------------+--------------------------
//  event_ch   | in        | event_word_t  | valid/ready
//  result_ch  | out       | result_word_t | valid/ready, output register
//  cfg_*      | in        | 32-bit data   | write enable, no wait
//
// A word is taken only in the idle state and then owns the datapath until its result is
// loaded into the output register. A word with no result returns to idle, a stop word goes
// to S_EMIT, a sample runs S_REG, S_NORM, S_LIMIT, S_EMIT; a later one that does not regress
// adds S_STEP and S_GAP, and a gap with a nonzero interval a 64-step restoring divide (S_DIV)
// on the shared subtractor and S_DROP. Reset clears counters and flags, loads the register
// defaults; a stalled output holds the sequencer in its emit state, and takes no input word.
module frame_timestamp_gap_monitor
    import ftgm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ftgm_chan_if.sink              event_ch,
    ftgm_chan_if.source            result_ch
);

    localparam logic [COUNT_BITS-1:0] CountMax  = {COUNT_BITS{1'b1}};
    localparam logic [DIV_CNT_W-1:0]  DivLast   = DIV_CNT_W'(DIV_STEPS - 1);
    localparam logic [BYTE_W-1:0]     ByteMax   = {BYTE_W{1'b1}};

    state_t state_reg, state_next;

    logic [31:0]            interval_reg;
    logic [15:0]            duration_reg;
    logic                   finalize_reg;

    event_word_t            in_reg;
    logic [63:0]            first_time_reg;
    logic [63:0]            previous_time_reg;
    logic                   have_first_reg;
    logic [COUNT_BITS-1:0]  sample_count_reg;
    logic [COUNT_BITS-1:0]  tick_count_reg;
    logic [COUNT_BITS-1:0]  regression_count_reg;
    logic [BYTE_W-1:0]      bytes_seen_reg;
    logic                   stopped_reg;

    logic [63:0]            step_reg;
    logic [31:0]            rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [63:0]            norm_reg;
    logic [39:0]            limit_reg;
    logic [COUNT_BITS-1:0]  seq_reg;
    disc_t                  disc_reg;
    logic [31:0]            dropped_reg;
    stop_t                  reason_reg;

    result_word_t           out_reg;
    logic                   out_valid_reg;

    logic [63:0]            alu_a;
    logic [63:0]            alu_b;
    logic [64:0]            alu_diff;
    logic                   alu_borrow;
    logic [32:0]            trial;
    logic [33:0]            gap_limit;
    logic [BYTE_W:0]        byte_sum;
    logic                   out_free;
    logic                   is_stop_event;
    logic [63:0]            seq_wide;
    logic [63:0]            tick_wide;
    logic [63:0]            regr_wide;

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[64];
    assign trial      = {rem_reg, step_reg[63]};
    assign gap_limit  = {2'b00, interval_reg} + {3'b000, interval_reg[31:1]};
    assign byte_sum   = {1'b0, bytes_seen_reg} + (BYTE_W + 1)'(in_reg.sample_bytes);
    assign out_free   = !out_valid_reg || result_ch.ready;
    assign is_stop_event = in_reg.read_failed || in_reg.error_flag
                        || in_reg.type_changed || in_reg.stream_end;
    assign seq_wide   = 64'(seq_reg);
    assign tick_wide  = 64'(tick_count_reg);
    assign regr_wide  = 64'(regression_count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (event_ch.valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                priority if (stopped_reg)
                    state_next = S_IDLE;
                else if (is_stop_event)
                    state_next = S_EMIT;
                else if (!in_reg.sample_present)
                    state_next = S_IDLE;
                else
                    state_next = S_REG;
            end
            S_REG:
            begin
                priority if (alu_borrow)
                    state_next = S_NORM;
                else if (sample_count_reg != '0)
                    state_next = S_STEP;
                else
                    state_next = S_NORM;
            end
            S_STEP:  state_next = S_GAP;
            S_GAP:
            begin
                if (alu_borrow && interval_reg != '0)
                    state_next = S_DIV;
                else
                    state_next = S_NORM;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DivLast)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:  state_next = S_NORM;
            S_NORM:  state_next = S_LIMIT;
            S_LIMIT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        event_ch.ready = (state_reg == S_IDLE);
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            S_REG:
            begin
                alu_a = in_reg.event_time ^ SIGN64;
                alu_b = previous_time_reg ^ SIGN64;
            end
            S_STEP:
            begin
                alu_a = in_reg.event_time;
                alu_b = previous_time_reg;
            end
            S_GAP:
            begin
                alu_a = 64'(gap_limit);
                alu_b = step_reg;
            end
            S_DIV:
            begin
                alu_a = 64'(trial);
                alu_b = 64'(interval_reg);
            end
            S_DROP:
            begin
                alu_a = step_reg;
                alu_b = 64'd1;
            end
            S_NORM:
            begin
                alu_a = in_reg.event_time;
                alu_b = first_time_reg;
            end
            S_LIMIT:
            begin
                alu_a = norm_reg;
                alu_b = 64'(limit_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            interval_reg         <= INTERVAL_RESET;
            duration_reg         <= DURATION_RESET;
            finalize_reg         <= 1'b0;
            first_time_reg       <= '0;
            previous_time_reg    <= '0;
            have_first_reg       <= 1'b0;
            sample_count_reg     <= '0;
            tick_count_reg       <= '0;
            regression_count_reg <= '0;
            bytes_seen_reg       <= '0;
            stopped_reg          <= 1'b0;
            div_cnt_reg          <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_INTERVAL: interval_reg <= cfg_data;
                    CFG_DURATION:       duration_reg <= cfg_data[15:0];
                    CFG_FINALIZE:       finalize_reg <= cfg_data[0];
                    default:            ;
                endcase
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (event_ch.valid)
                    begin
                        in_reg <= event_ch.data;
                    end
                end
                S_EVAL:
                begin
                    disc_reg    <= DISC_NONE;
                    dropped_reg <= '0;
                    norm_reg    <= '0;
                    seq_reg     <= sample_count_reg;
                    if (stopped_reg)
                    begin
                        reason_reg <= STOP_RUNNING;
                    end
                    else
                    begin
                        priority if (in_reg.read_failed || in_reg.error_flag)
                        begin
                            stopped_reg <= 1'b1;
                            if (!finalize_reg || sample_count_reg == '0)
                                reason_reg <= STOP_ABORTED;
                            else if (in_reg.read_failed)
                                reason_reg <= STOP_READ_ERROR;
                            else
                                reason_reg <= STOP_ERROR_FLAG;
                        end
                        else
                        begin
                            if (in_reg.tick_flag && tick_count_reg != CountMax)
                            begin
                                tick_count_reg <= tick_count_reg + 1'b1;
                            end
                            priority if (in_reg.type_changed)
                            begin
                                stopped_reg <= 1'b1;
                                reason_reg  <= STOP_ABORTED;
                            end
                            else if (in_reg.stream_end)
                            begin
                                stopped_reg <= 1'b1;
                                reason_reg  <= (sample_count_reg == '0) ? STOP_ABORTED
                                                                        : STOP_END;
                            end
                            else if (in_reg.sample_present && !have_first_reg)
                            begin
                                first_time_reg    <= in_reg.event_time;
                                previous_time_reg <= in_reg.event_time;
                                have_first_reg    <= 1'b1;
                                reason_reg        <= STOP_RUNNING;
                            end
                            else
                            begin
                                reason_reg <= STOP_RUNNING;
                            end
                        end
                    end
                end
                S_REG:
                begin
                    if (alu_borrow)
                    begin
                        disc_reg <= DISC_REGRESSION;
                        if (regression_count_reg != CountMax)
                        begin
                            regression_count_reg <= regression_count_reg + 1'b1;
                        end
                    end
                end
                S_STEP:
                begin
                    step_reg <= alu_diff[63:0];
                end
                S_GAP:
                begin
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    if (alu_borrow)
                    begin
                        disc_reg <= DISC_GAP;
                    end
                end
                S_DIV:
                begin
                    // Step register shifts out the dividend and takes in the quotient.
                    rem_reg     <= alu_borrow ? trial[31:0] : alu_diff[31:0];
                    step_reg    <= {step_reg[62:0], !alu_borrow};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                S_DROP:
                begin
                    priority if (alu_borrow)
                        dropped_reg <= '0;
                    else if (alu_diff[63:32] != '0)
                        dropped_reg <= '1;
                    else
                        dropped_reg <= alu_diff[31:0];
                end
                S_NORM:
                begin
                    if (in_reg.tick_flag)
                    begin
                        disc_reg <= DISC_GAP;
                    end
                    norm_reg          <= alu_diff[63:0];
                    bytes_seen_reg    <= byte_sum[BYTE_W] ? ByteMax : byte_sum[BYTE_W-1:0];
                    previous_time_reg <= in_reg.event_time;
                    seq_reg           <= sample_count_reg;
                    if (sample_count_reg != CountMax)
                    begin
                        sample_count_reg <= sample_count_reg + 1'b1;
                    end
                    limit_reg <= 40'(duration_reg) * 40'(TICKS_PER_SECOND);
                end
                S_LIMIT:
                begin
                    if (!norm_reg[63] && !alu_borrow)
                    begin
                        stopped_reg <= 1'b1;
                        reason_reg  <= STOP_DURATION;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg.frame_sequence   <= seq_wide[31:0];
                        out_reg.discontinuity    <= disc_reg;
                        out_reg.frames_missed    <= dropped_reg;
                        out_reg.normalized_time  <= norm_reg;
                        out_reg.stop_reason      <= reason_reg;
                        out_reg.byte_total       <= bytes_seen_reg;
                        out_reg.tick_total       <= tick_wide[31:0];
                        out_reg.regression_total <= regr_wide[31:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("Stopped flag cleared without reset.");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg != DivLast) |=> state_reg == S_DIV)
        else $error("Divide left before its last step.");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> sample_count_reg >= $past(sample_count_reg))
        else $error("Sample count went down.");

    a_stop_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stop_reason != STOP_RUNNING
            && out_reg.stop_reason != STOP_DURATION)
        |-> (out_reg.discontinuity == DISC_NONE && out_reg.frames_missed == '0
            && out_reg.normalized_time == '0))
        else $error("Stop word carries sample fields.");

endmodule

>>> sim/tb_frame_timestamp_gap_monitor.sv
// Self-checking testbench for the frame timestamp gap monitor with a built-in predictor.
module tb_frame_timestamp_gap_monitor;
    import ftgm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES  = 100;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] BASE_TS        = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] MAX_TS         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_TS         = 64'h8000_0000_0000_0000;

    typedef enum int {
        END_BY_DURATION,
        END_BY_STREAM,
        END_BY_READ,
        END_BY_FLAG,
        END_BY_TYPE,
        END_BY_ZERO_DURATION
    } stop_cause_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ftgm_chan_if #(.word_t(event_word_t))  event_if ();
    ftgm_chan_if #(.word_t(result_word_t)) result_if ();

    frame_timestamp_gap_monitor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .event_ch  (event_if),
        .result_ch (result_if)
    );

    // Predictor state and its copy of the registers.
    logic [31:0]  interval_cfg;
    logic [15:0]  duration_cfg;
    bit           finalize_cfg;
    logic [63:0]  first_ts;
    logic [63:0]  last_ts;
    bit           seen_first;
    bit           halted;
    logic [31:0]  frames_seen;
    logic [31:0]  ticks_seen;
    logic [31:0]  regressions_seen;
    logic [47:0]  bytes_sum;

    result_word_t expected_results[$];
    result_word_t want_word;
    result_word_t got_word;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           rx_stall_left = 0;
    bit           tx_gaps_on;
    bit           rx_stalls_on;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] duration_limit();
        return 64'(duration_cfg) * 64'(TICKS_PER_SECOND);
    endfunction

    function automatic result_word_t make_result(input logic [31:0] seq, input logic [1:0] disc,
                                                 input logic [31:0] drop, input logic [63:0] norm,
                                                 input logic [2:0] why);
        result_word_t r;
        r.frame_sequence   = seq;
        r.discontinuity    = disc;
        r.frames_missed    = drop;
        r.normalized_time  = norm;
        r.stop_reason      = why;
        r.byte_total       = bytes_sum;
        r.tick_total       = ticks_seen;
        r.regression_total = regressions_seen;
        return r;
    endfunction

    function automatic bit predict_event(input event_word_t e, output result_word_t r);
        logic [63:0] ts;
        logic [63:0] step;
        logic [63:0] thr;
        logic [63:0] elapsed;
        logic [63:0] norm;
        logic [31:0] drop;
        logic [31:0] seq;
        logic [1:0]  disc;
        logic [48:0] sum;
        r    = '0;
        ts   = e.event_time;
        disc = DISC_NONE;
        drop = '0;
        if (halted)
            return 1'b0;
        if (e.read_failed || e.error_flag)
        begin
            halted = 1'b1;
            if (!finalize_cfg || frames_seen == 0)
                r = make_result(frames_seen, DISC_NONE, '0, '0, STOP_ABORTED);
            else if (e.read_failed)
                r = make_result(frames_seen, DISC_NONE, '0, '0, STOP_READ_ERROR);
            else
                r = make_result(frames_seen, DISC_NONE, '0, '0, STOP_ERROR_FLAG);
            return 1'b1;
        end
        if (e.tick_flag)
            ticks_seen = bump(ticks_seen);
        if (e.type_changed)
        begin
            halted = 1'b1;
            r = make_result(frames_seen, DISC_NONE, '0, '0, STOP_ABORTED);
            return 1'b1;
        end
        if (e.stream_end)
        begin
            halted = 1'b1;
            r = make_result(frames_seen, DISC_NONE, '0, '0,
                            (frames_seen == 0) ? STOP_ABORTED : STOP_END);
            return 1'b1;
        end
        if (!e.sample_present)
            return 1'b0;

        if (!seen_first)
        begin
            first_ts   = ts;
            last_ts    = ts;
            seen_first = 1'b1;
        end
        if ($signed(ts) < $signed(last_ts))
        begin
            disc = DISC_REGRESSION;
            regressions_seen = bump(regressions_seen);
        end
        else if (frames_seen != 0)
        begin
            step = ts - last_ts;
            thr  = (64'(interval_cfg) * 64'd3) / 64'd2;
            if (step > thr)
            begin
                elapsed = (interval_cfg != 0) ? step / 64'(interval_cfg) : 64'd1;
                disc = DISC_GAP;
                if (elapsed <= 64'd1)
                    drop = '0;
                else if (elapsed - 64'd1 > 64'h0000_0000_FFFF_FFFF)
                    drop = '1;
                else
                    drop = 32'(elapsed - 64'd1);
            end
        end
        if (e.tick_flag)
            disc = DISC_GAP;

        sum       = {1'b0, bytes_sum} + 49'(e.sample_bytes);
        bytes_sum = sum[48] ? '1 : sum[47:0];
        norm      = ts - first_ts;
        last_ts   = ts;
        seq       = frames_seen;
        frames_seen = bump(frames_seen);
        if (!norm[63] && norm >= duration_limit())
            halted = 1'b1;
        r = make_result(seq, disc, drop, norm, halted ? STOP_DURATION : STOP_RUNNING);
        return 1'b1;
    endfunction

    // Moves a timestamp that would trip the duration limit back into the running range.
    function automatic logic [63:0] keep_running(input logic [63:0] ts);
        logic [63:0] norm;
        if (!seen_first)
            return ts;
        norm = ts - first_ts;
        if (norm[63] || norm < duration_limit())
            return ts;
        if ($urandom_range(0, 1))
            return first_ts + {1'b1, 31'($urandom), $urandom};
        return first_ts + ({$urandom, $urandom} % duration_limit());
    endfunction

    function automatic logic [63:0] next_timestamp();
        logic [63:0] base;
        logic [63:0] iv;
        logic [63:0] jitter;
        logic [63:0] ts;
        iv     = 64'(interval_cfg);
        base   = seen_first ? last_ts : {$urandom, $urandom};
        jitter = 64'($urandom_range(0, interval_cfg >> 3)) + 64'($urandom_range(0, 3));
        case ($urandom_range(0, 19))
            10, 11, 12: ts = base + iv * 64'($urandom_range(2, 12)) + jitter;
            13, 14:     ts = base - 64'($urandom_range(1, 1000)) * (iv + 64'd1);
            15:         ts = base;
            16, 17:     ts = {$urandom, $urandom};
            18:         ts = $urandom_range(0, 1) ? MAX_TS : MIN_TS;
            19:         ts = base + ({$urandom, $urandom} >> $urandom_range(0, 63));
            default:    ts = base + iv + jitter;
        endcase
        return keep_running(ts);
    endfunction

    function automatic logic [31:0] random_bytes();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(500, 200_000);
        endcase
    endfunction

    function automatic event_word_t sample_word(input logic [63:0] ts, input logic [31:0] nbytes,
                                                input bit tick);
        event_word_t e;
        e = '0;
        e.event_time     = ts;
        e.sample_present = 1'b1;
        e.sample_bytes   = nbytes;
        e.tick_flag      = tick;
        return e;
    endfunction

    function automatic event_word_t idle_word(input bit tick);
        event_word_t e;
        e = '0;
        e.event_time   = {$urandom, $urandom};
        e.sample_bytes = $urandom;
        e.tick_flag    = tick;
        return e;
    endfunction

    function automatic event_word_t random_word();
        event_word_t e;
        e.event_time     = {$urandom, $urandom};
        e.sample_present = 1'($urandom_range(0, 1));
        e.sample_bytes   = $urandom;
        e.read_failed    = 1'($urandom_range(0, 1));
        e.error_flag     = 1'($urandom_range(0, 1));
        e.tick_flag      = 1'($urandom_range(0, 1));
        e.type_changed   = 1'($urandom_range(0, 1));
        e.stream_end     = 1'($urandom_range(0, 1));
        return e;
    endfunction

    function automatic event_word_t random_item();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return sample_word(next_timestamp(), random_bytes(), $urandom_range(0, 19) == 0);
        if (roll < 90)
            return idle_word(1'($urandom_range(0, 1)));
        return sample_word(next_timestamp(), random_bytes(), 1'b1);
    endfunction

    task automatic send_event(input event_word_t e);
        result_word_t predicted;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            event_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        event_if.valid <= 1'b1;
        event_if.data  <= e;
        do
            @(posedge clk);
        while (!event_if.ready);
        if (predict_event(e, predicted))
            expected_results.insert(expected_results.size(), predicted);
    endtask

    task automatic wait_results_done();
        event_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] iv, input logic [15:0] dur, input bit fin);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_INTERVAL;
        cfg_data  <= iv;
        @(posedge clk);
        cfg_index <= CFG_DURATION;
        cfg_data  <= CFG_DATA_W'(dur);
        @(posedge clk);
        cfg_index <= CFG_FINALIZE;
        cfg_data  <= CFG_DATA_W'(fin);
        @(posedge clk);
        cfg_we <= 1'b0;
        interval_cfg = iv;
        duration_cfg = dur;
        finalize_cfg = fin;
    endtask

    task automatic test_idle_words();
        send_event(idle_word(1'b0));
        send_event(idle_word(1'b1));
    endtask

    task automatic test_sample_steps();
        send_event(sample_word(BASE_TS, 32'hFFFF_FFFF, 1'b1));
        send_event(sample_word(BASE_TS + 64'(INTERVAL_RESET), 32'd0, 1'b0));
        send_event(sample_word(BASE_TS + 64'(INTERVAL_RESET) * 6, 32'd1500, 1'b0));
        send_event(sample_word(BASE_TS + 64'(INTERVAL_RESET) * 6, 32'd1500, 1'b0));
    endtask

    task automatic test_wide_steps();
        send_event(sample_word(BASE_TS - 64'd10, 32'd7, 1'b0));
        send_event(sample_word(MIN_TS, 32'h8000_0000, 1'b0));
        send_event(sample_word(MAX_TS, 32'h7FFF_FFFF, 1'b0));
        send_event(sample_word(MAX_TS, 32'd1, 1'b1));
    endtask

    task automatic test_interval_extremes();
        wait_results_done();
        set_config(32'd0, 16'hFFFF, 1'b1);
        send_event(sample_word(BASE_TS + 64'd100, 32'd10, 1'b0));
        send_event(sample_word(BASE_TS + 64'd101, 32'd10, 1'b0));
        send_event(sample_word(BASE_TS + 64'd101, 32'd10, 1'b0));
        wait_results_done();
        set_config(32'hFFFF_FFFF, 16'd1, 1'b0);
        send_event(sample_word(BASE_TS - (64'd1 << 40), 32'd20, 1'b0));
        send_event(sample_word(last_ts + 64'h0000_0000_FFFF_FFFF * 3, 32'd20, 1'b0));
        send_event(sample_word(last_ts + 64'h0000_0000_FFFF_FFFF, 32'd20, 1'b0));
    endtask

    task automatic run_phase(input logic [31:0] iv, input logic [15:0] dur, input bit fin,
                             input int count);
        wait_results_done();
        set_config(iv, dur, fin);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_results_done();
            send_event(random_item());
        end
    endtask

    task automatic test_random_phases();
        run_phase(INTERVAL_RESET, DURATION_RESET, 1'b0, 80);
        run_phase(32'd0, 16'd1, 1'b1, 80);
        run_phase(32'd1, 16'hFFFF, 1'b0, 80);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 80);
        run_phase($urandom_range(1000, 5_000_000), 16'($urandom_range(1, 16'hFFFF)),
                  1'($urandom_range(0, 1)), 80);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        run_phase(INTERVAL_RESET, 16'($urandom_range(1, 600)), 1'($urandom_range(0, 1)), 80);
    endtask

    task automatic test_final_stop();
        event_word_t e;
        stop_cause_t cause;
        bit          fin;
        fin   = 1'($urandom_range(0, 1));
        cause = stop_cause_t'($urandom_range(0, 5));
        wait_results_done();
        set_config(interval_cfg, (cause == END_BY_ZERO_DURATION) ? 16'd0 : duration_cfg, fin);
        e = random_word();
        e.read_failed  = 1'b0;
        e.error_flag   = 1'b0;
        e.type_changed = 1'b0;
        case (cause)
            END_BY_DURATION:
                e = sample_word(first_ts + duration_limit() + 64'($urandom_range(0, 1000)),
                                random_bytes(), 1'($urandom_range(0, 1)));
            END_BY_STREAM:
                e.stream_end = 1'b1;
            END_BY_READ:
            begin
                e.read_failed  = 1'b1;
                e.error_flag   = 1'($urandom_range(0, 1));
                e.type_changed = 1'($urandom_range(0, 1));
            end
            END_BY_FLAG:
            begin
                e.error_flag   = 1'b1;
                e.type_changed = 1'($urandom_range(0, 1));
            end
            END_BY_TYPE:
                e.type_changed = 1'b1;
            END_BY_ZERO_DURATION:
                e = sample_word(first_ts + 64'($urandom_range(0, 1000)), random_bytes(),
                                1'($urandom_range(0, 1)));
        endcase
        send_event(e);
        repeat (8) send_event(random_word());
    endtask

    always @(posedge clk)
    begin
        if (rx_stall_left != 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (rx_stalls_on && $urandom_range(0, 4) == 0)
        begin
            rx_stall_left = $urandom_range(1, 5) - 1;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with no prediction waiting");
                mismatches++;
            end
            else
            begin
                want_word = expected_results.pop_front();
                got_word  = result_if.data;
                if (got_word.frame_sequence !== want_word.frame_sequence)
                begin
                    $error("frame_sequence: expected %0d, got %0d",
                           want_word.frame_sequence, got_word.frame_sequence);
                    mismatches++;
                end
                if (got_word.discontinuity !== want_word.discontinuity)
                begin
                    $error("discontinuity: expected %0d, got %0d",
                           want_word.discontinuity, got_word.discontinuity);
                    mismatches++;
                end
                if (got_word.frames_missed !== want_word.frames_missed)
                begin
                    $error("frames_missed: expected %0d, got %0d",
                           want_word.frames_missed, got_word.frames_missed);
                    mismatches++;
                end
                if (got_word.normalized_time !== want_word.normalized_time)
                begin
                    $error("normalized_time: expected %0d, got %0d",
                           want_word.normalized_time, got_word.normalized_time);
                    mismatches++;
                end
                if (got_word.stop_reason !== want_word.stop_reason)
                begin
                    $error("stop_reason: expected %0d, got %0d",
                           want_word.stop_reason, got_word.stop_reason);
                    mismatches++;
                end
                if (got_word.byte_total !== want_word.byte_total)
                begin
                    $error("byte_total: expected %0d, got %0d",
                           want_word.byte_total, got_word.byte_total);
                    mismatches++;
                end
                if (got_word.tick_total !== want_word.tick_total)
                begin
                    $error("tick_total: expected %0d, got %0d",
                           want_word.tick_total, got_word.tick_total);
                    mismatches++;
                end
                if (got_word.regression_total !== want_word.regression_total)
                begin
                    $error("regression_total: expected %0d, got %0d",
                           want_word.regression_total, got_word.regression_total);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (event_if.valid && event_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $error("no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_FRAME_INTERVAL;
        cfg_data        = '0;
        event_if.valid  = 1'b0;
        event_if.data   = '0;
        tx_gaps_on      = 1'b1;
        rx_stalls_on    = 1'b1;
        interval_cfg     = INTERVAL_RESET;
        duration_cfg     = DURATION_RESET;
        finalize_cfg     = 1'b0;
        first_ts         = '0;
        last_ts          = '0;
        seen_first       = 1'b0;
        halted           = 1'b0;
        frames_seen      = '0;
        ticks_seen       = '0;
        regressions_seen = '0;
        bytes_sum        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_words();
        test_sample_steps();
        test_wide_steps();
        test_interval_extremes();
        test_random_phases();
        test_final_stop();

        wait_results_done();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
